>>> rtl/core/scpf_pkg.sv
// shared types and constants for the sum-checked packet framer
`default_nettype none

package scpf_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned MAX_BURST = 5;
	localparam int unsigned CNT_W     = $clog2(MAX_BURST + 1);

	// request codes
	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd170;

	typedef struct packed {
		logic              req_type;
		logic [BYTE_W-1:0] msg_id;
		logic [BYTE_W-1:0] payload_len;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	// bytes produced by one item, entry 0 goes out first
	typedef struct packed {
		logic [CNT_W-1:0]                 count;
		logic [MAX_BURST-1:0][BYTE_W-1:0] bytes;
		logic                             close;
	} burst_t;

endpackage

`default_nettype wire

>>> rtl/core/scpf_in_stage.sv
// input register stage holding one accepted request item
`default_nettype none

module scpf_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           src_valid,
	output logic                src_stall,
	input  wire scpf_pkg::item_t src_item,
	input  wire logic           advance,
	output logic                valid_s1,
	output scpf_pkg::item_t     item_s1
);

	assign src_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/scpf_core.sv
// frame state and composition of the output bytes for one item
`default_nettype none

module scpf_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire scpf_pkg::item_t             item_s1,
	input  wire logic [scpf_pkg::BYTE_W-1:0] header_q,
	output scpf_pkg::burst_t                 burst
);

	logic [scpf_pkg::BYTE_W-1:0] seq_q;
	logic [scpf_pkg::BYTE_W-1:0] sum_q;
	logic [scpf_pkg::BYTE_W-1:0] remain_q;
	logic                        open_q;

	logic [scpf_pkg::BYTE_W-1:0] seq_d;
	logic [scpf_pkg::BYTE_W-1:0] sum_d;
	logic [scpf_pkg::BYTE_W-1:0] remain_d;
	logic                        open_d;
	logic [scpf_pkg::BYTE_W-1:0] hdr_sum;
	logic [scpf_pkg::BYTE_W-1:0] pay_sum;

	assign hdr_sum = header_q + item_s1.payload_len + seq_q + item_s1.msg_id;
	assign pay_sum = sum_q + item_s1.data_byte;

	always_comb begin
		seq_d        = seq_q;
		sum_d        = sum_q;
		remain_d     = remain_q;
		open_d       = open_q;
		burst.count  = '0;
		burst.close  = 1'b0;
		burst.bytes  = '0;
		if (item_s1.req_type == scpf_pkg::REQ_START) begin
			// a start while a frame is open is dropped
			if (!open_q) begin
				burst.bytes[0] = header_q;
				burst.bytes[1] = item_s1.payload_len;
				burst.bytes[2] = seq_q;
				burst.bytes[3] = item_s1.msg_id;
				burst.bytes[4] = hdr_sum;
				seq_d          = seq_q + 8'd1;
				if (item_s1.payload_len == '0) begin
					burst.count = scpf_pkg::CNT_W'(5);
					burst.close = 1'b1;
					sum_d       = '0;
				end else begin
					burst.count = scpf_pkg::CNT_W'(4);
					sum_d       = hdr_sum;
					remain_d    = item_s1.payload_len;
					open_d      = 1'b1;
				end
			end
		end else begin
			if (open_q) begin
				burst.bytes[0] = item_s1.data_byte;
				burst.bytes[1] = pay_sum;
				if (remain_q == 8'd1) begin
					burst.count = scpf_pkg::CNT_W'(2);
					burst.close = 1'b1;
					sum_d       = '0;
					remain_d    = '0;
					open_d      = 1'b0;
				end else begin
					burst.count = scpf_pkg::CNT_W'(1);
					sum_d       = pay_sum;
					remain_d    = remain_q - 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= '0;
			sum_q    <= '0;
			remain_q <= '0;
			open_q   <= 1'b0;
		end else if (advance) begin
			seq_q    <= seq_d;
			sum_q    <= sum_d;
			remain_q <= remain_d;
			open_q   <= open_d;
		end
	end

	a_open_has_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (remain_q != '0))
		else $error("frame open with no payload bytes left");

	a_closed_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (sum_q == '0))
		else $error("running sum not cleared outside a frame");

	a_drop_no_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && burst.count == '0) |=> ($stable(seq_q) && $stable(open_q)))
		else $error("dropped item changed frame state");

endmodule

`default_nettype wire

>>> rtl/core/scpf_out_buf.sv
// result register that shifts out the bytes of one item
`default_nettype none

module scpf_out_buf (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire scpf_pkg::burst_t            burst,
	output logic                             free,
	output logic                             dst_valid,
	input  wire logic                        dst_stall,
	output logic [scpf_pkg::BYTE_W-1:0]      out_byte,
	output logic                             end_of_frame
);

	logic [scpf_pkg::MAX_BURST-1:0][scpf_pkg::BYTE_W-1:0] bytes_s2;
	logic [scpf_pkg::CNT_W-1:0]                           cnt_q;
	logic                                                 close_q;
	logic                                                 pop;

	assign dst_valid    = (cnt_q != '0);
	assign pop          = dst_valid && !dst_stall;
	// empty now, or the last byte leaves this cycle
	assign free         = (cnt_q == '0) || ((cnt_q == scpf_pkg::CNT_W'(1)) && pop);
	assign out_byte     = bytes_s2[0];
	assign end_of_frame = close_q && (cnt_q == scpf_pkg::CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			close_q <= 1'b0;
		end else if (load) begin
			cnt_q   <= burst.count;
			close_q <= burst.close;
		end else if (pop) begin
			cnt_q   <= cnt_q - scpf_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= burst.bytes;
		end else if (pop) begin
			for (int i = 0; i < scpf_pkg::MAX_BURST - 1; i++) begin
				bytes_s2[i] <= bytes_s2[i+1];
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= scpf_pkg::CNT_W'(scpf_pkg::MAX_BURST))
		else $error("byte count out of range");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("burst loaded over bytes not yet sent");

	a_pop_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !load) |=> (cnt_q == $past(cnt_q) - scpf_pkg::CNT_W'(1)))
		else $error("byte count did not follow a sent byte");

endmodule

`default_nettype wire

>>> rtl/core/sum_checked_packet_framer.sv
// Length-prefixed packet framer with an 8-bit additive checksum.
// The request channel (src_valid/src_stall) takes items: a start request
// (req_type 0) with msg_id and payload_len, or a payload byte (req_type 1)
// with data_byte. The result channel (dst_valid/dst_stall) gives one byte a
// cycle: header, length, sequence number, message id, then payload bytes,
// then the checksum with end_of_frame high. Zero-length frames close at once.
// An item is registered in the input stage, then its bytes are loaded into
// the output shift register once it is empty or sending its last byte.
// A start produces four bytes (five when empty), a payload byte one, and the
// last payload byte two, with the checksum. The output shift register sends
// them one per cycle while dst_stall is low, and takes the next item's bytes
// as its last byte leaves. Dropped items (payload with no frame, start inside
// a frame) produce no bytes.
// cfg_we/cfg_data write the header byte; it is sampled when a start is
// processed. Reset (arst_n low) sets header 170, sequence 0, no frame open.
// When the receiver stalls, the current byte holds and requests back up
// through src_stall once the held item cannot move on.
`default_nettype none

module sum_checked_packet_framer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data,
	input  wire logic       src_valid,
	output logic            src_stall,
	input  wire logic       req_type,
	input  wire logic [7:0] msg_id,
	input  wire logic [7:0] payload_len,
	input  wire logic [7:0] data_byte,
	output logic            dst_valid,
	input  wire logic       dst_stall,
	output logic [7:0]      out_byte,
	output logic            end_of_frame
);

	logic [scpf_pkg::BYTE_W-1:0] header_q;
	scpf_pkg::item_t             src_item;
	scpf_pkg::item_t             item_s1;
	scpf_pkg::burst_t            burst;
	logic                        valid_s1;
	logic                        advance;
	logic                        free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= scpf_pkg::HEADER_RESET;
		end else if (cfg_we) begin
			header_q <= cfg_data;
		end
	end

	assign src_item.req_type    = req_type;
	assign src_item.msg_id      = msg_id;
	assign src_item.payload_len = payload_len;
	assign src_item.data_byte   = data_byte;

	assign advance = valid_s1 && free;

	scpf_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	scpf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item_s1  (item_s1),
		.header_q (header_q),
		.burst    (burst)
	);

	scpf_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.burst        (burst),
		.free         (free),
		.dst_valid    (dst_valid),
		.dst_stall    (dst_stall),
		.out_byte     (out_byte),
		.end_of_frame (end_of_frame)
	);

endmodule

`default_nettype wire

>>> dv/sum_checked_packet_framer_tb.sv
// testbench for the sum-checked packet framer: directed and random frames checked per byte
`timescale 1ns / 100ps

module sum_checked_packet_framer_tb;

	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [scpf_pkg::BYTE_W-1:0] value;
		logic                        last;
	} framed_byte_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [7:0]        cfg_data;
	logic              src_valid;
	logic              src_stall;
	logic              req_type;
	logic [7:0]        msg_id;
	logic [7:0]        payload_len;
	logic [7:0]        data_byte;
	logic              dst_valid;
	logic              dst_stall;
	logic [7:0]        out_byte;
	logic              end_of_frame;

	// framer model state
	logic [scpf_pkg::BYTE_W-1:0] hdr_model;
	logic [scpf_pkg::BYTE_W-1:0] seq_model;
	logic [scpf_pkg::BYTE_W-1:0] frame_sum;
	logic [scpf_pkg::BYTE_W-1:0] bytes_left;
	logic                        in_frame;

	framed_byte_t      expected_bytes[$];

	int                src_idle_pct;
	int                dst_stall_pct;
	int                dst_hold_cycles;
	int                mismatch_count;
	int                items_sent;
	int                bytes_checked;
	int                frames_checked;
	int                header_writes;

	sum_checked_packet_framer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.req_type     (req_type),
		.msg_id       (msg_id),
		.payload_len  (payload_len),
		.data_byte    (data_byte),
		.dst_valid    (dst_valid),
		.dst_stall    (dst_stall),
		.out_byte     (out_byte),
		.end_of_frame (end_of_frame)
	);

	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("timeout: %0d bytes still expected", expected_bytes.size());
		$display("Mismatches found");
		$finish;
	end

	function automatic void push_counted(input logic [scpf_pkg::BYTE_W-1:0] b);
		framed_byte_t fb;
		fb.value = b;
		fb.last = 1'b0;
		frame_sum = frame_sum + b;
		expected_bytes.push_back(fb);
	endfunction

	function automatic void close_frame();
		framed_byte_t fb;
		fb.value = frame_sum;
		fb.last = 1'b1;
		expected_bytes.push_back(fb);
		frame_sum = '0;
		bytes_left = '0;
		in_frame = 1'b0;
	endfunction

	// expected bytes for one accepted item
	function automatic void predict_frame_bytes(input logic rq, input logic [7:0] id,
			input logic [7:0] len, input logic [7:0] dat);
		if (rq == scpf_pkg::REQ_START) begin
			if (!in_frame) begin
				frame_sum = '0;
				push_counted(hdr_model);
				push_counted(len);
				push_counted(seq_model);
				push_counted(id);
				seq_model = seq_model + 8'd1;
				if (len == 8'd0) begin
					close_frame();
				end else begin
					bytes_left = len;
					in_frame = 1'b1;
				end
			end
		end else if (in_frame) begin
			push_counted(dat);
			bytes_left = bytes_left - 8'd1;
			if (bytes_left == 8'd0) begin
				close_frame();
			end
		end
	endfunction

	function automatic void report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("mismatch at %0t: %s", $realtime, what);
		end
	endfunction

	task automatic send_item(input logic rq, input logic [7:0] id, input logic [7:0] len,
			input logic [7:0] dat);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			req_type <= 1'($urandom);
			msg_id <= 8'($urandom);
			payload_len <= 8'($urandom);
			data_byte <= 8'($urandom);
			@(posedge clk);
		end
		src_valid <= 1'b1;
		req_type <= rq;
		msg_id <= id;
		payload_len <= len;
		data_byte <= dat;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		predict_frame_bytes(rq, id, len, dat);
		items_sent++;
	endtask

	// sender pauses until every expected byte is out and the pipeline is empty
	task automatic wait_idle();
		src_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_header(input logic [7:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		hdr_model = v;
		header_writes++;
	endtask

	task automatic test_directed();
		src_idle_pct = 0;
		dst_stall_pct = 0;
		// reset header value, empty frame
		send_item(scpf_pkg::REQ_START, 8'h00, 8'd0, 8'h00);
		// payload with no frame open is dropped
		send_item(scpf_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'hFF);
		send_item(scpf_pkg::REQ_START, 8'hFF, 8'd1, 8'h00);
		// start inside an open frame is dropped
		send_item(scpf_pkg::REQ_START, 8'h12, 8'd255, 8'h00);
		send_item(scpf_pkg::REQ_PAYLOAD, 8'hFF, 8'hFF, 8'hFF);
		send_item(scpf_pkg::REQ_START, 8'h5A, 8'd3, 8'h00);
		send_item(scpf_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'h00);
		send_item(scpf_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'h80);
		send_item(scpf_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'h7F);
		write_header(8'h00);
		send_item(scpf_pkg::REQ_START, 8'hFF, 8'd0, 8'h00);
		write_header(8'hFF);
		send_item(scpf_pkg::REQ_START, 8'h81, 8'd2, 8'h00);
		send_item(scpf_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'hFF);
		send_item(scpf_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'hFF);
		send_item(scpf_pkg::REQ_START, 8'hC3, 8'd6, 8'h00);
		send_item(scpf_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'h01);
		wait_idle();
	endtask

	// close the frame left open above, with a header write in the middle
	task automatic test_header_mid_frame();
		send_item(scpf_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'h11);
		write_header(8'h3C);
		while (in_frame) send_item(scpf_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'($urandom));
		send_item(scpf_pkg::REQ_START, 8'h44, 8'd0, 8'h00);
		wait_idle();
	endtask

	task automatic test_random(input int n, input int sp, input int dp);
		logic       rq;
		logic [7:0] id;
		logic [7:0] len;
		logic [7:0] dat;
		int         used;
		used = 0;
		src_idle_pct = sp;
		dst_stall_pct = dp;
		while (used < n) begin
			id = 8'($urandom);
			dat = 8'($urandom);
			len = 8'($urandom);
			if (in_frame) begin
				rq = ($urandom_range(99) < 92) ? scpf_pkg::REQ_PAYLOAD : scpf_pkg::REQ_START;
			end else begin
				rq = ($urandom_range(99) < 85) ? scpf_pkg::REQ_START : scpf_pkg::REQ_PAYLOAD;
				if ($urandom_range(19) != 0) begin
					len = 8'($urandom_range(0, 9));
				end else begin
					len = 8'($urandom_range(10, 40));
				end
			end
			if ((rq == scpf_pkg::REQ_START) != in_frame) begin
				used++;
			end
			send_item(rq, id, len, dat);
		end
	endtask

	// receiver holds off while the sender keeps offering payload
	task automatic test_backpressure();
		src_idle_pct = 0;
		dst_stall_pct = 0;
		while (in_frame) send_item(scpf_pkg::REQ_PAYLOAD, 8'h00, 8'h00, 8'($urandom));
		send_item(scpf_pkg::REQ_START, 8'($urandom), 8'd24, 8'h00);
		dst_hold_cycles = 80;
		repeat (24) send_item(scpf_pkg::REQ_PAYLOAD, 8'($urandom), 8'($urandom),
			8'($urandom));
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (dst_hold_cycles > 0) begin
			dst_stall <= 1'b1;
			dst_hold_cycles--;
		end else begin
			dst_stall <= ($urandom_range(99) < dst_stall_pct);
		end
	end

	always @(posedge clk) begin : check_output
		framed_byte_t want;
		if (arst_n && dst_valid && !dst_stall) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte,
					end_of_frame));
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.value || end_of_frame !== want.last) begin
					report_mismatch($sformatf("expected byte %02h last %0b, got %02h last %0b",
						want.value, want.last, out_byte, end_of_frame));
				end
				bytes_checked++;
				if (want.last) begin
					frames_checked++;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 8'h00;
		src_valid = 1'b0;
		req_type = scpf_pkg::REQ_START;
		msg_id = 8'h00;
		payload_len = 8'h00;
		data_byte = 8'h00;
		dst_stall = 1'b0;
		hdr_model = scpf_pkg::HEADER_RESET;
		seq_model = '0;
		frame_sum = '0;
		bytes_left = '0;
		in_frame = 1'b0;
		src_idle_pct = 0;
		dst_stall_pct = 0;
		dst_hold_cycles = 0;
		mismatch_count = 0;
		items_sent = 0;
		bytes_checked = 0;
		frames_checked = 0;
		header_writes = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_header_mid_frame();
		test_random(35, 0, 0);
		write_header(8'($urandom));
		test_random(35, 50, 0);
		write_header(8'hFF);
		test_random(35, 0, 50);
		write_header(8'h00);
		test_random(35, 13, 13);
		write_header(scpf_pkg::HEADER_RESET);
		test_random(25, 50, 50);
		test_backpressure();
		wait_idle();

		$display("covered: %0d items, %0d bytes in %0d frames, %0d header writes",
			items_sent, bytes_checked, frames_checked, header_writes);
		$display("dropped items, empty frames, header change inside a frame, long output hold-off");
		if (mismatch_count == 0 && expected_bytes.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches, %0d bytes never seen", mismatch_count,
				expected_bytes.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/scpf_pkg.sv
rtl/core/scpf_in_stage.sv
rtl/core/scpf_core.sv
rtl/core/scpf_out_buf.sv
rtl/core/sum_checked_packet_framer.sv
dv/sum_checked_packet_framer_tb.sv
